/* hdl/vog_pkg.sv */
`default_nettype none

package vog_pkg;

    // Fixed field widths
    localparam int FUNC_W    = 2;
    localparam int COORD_W   = 4;
    localparam int EDGE_W    = 5;
    localparam int STAT_W    = 2;
    localparam int IN_PAY_W  = 32;
    localparam int OUT_PAY_W = 32;

    // Index arithmetic width: an edge of up to 31 cells cubed stays below 2**15
    localparam int ACC_W = 15;

    // Packed stream words, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // Edge register value after reset
    localparam logic [EDGE_W-1:0] EDGE_RESET = 5'd16;

    // Operation codes carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_PROBE = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_ABSENT = 2'd2
    } t_status;

    // Neighbor visit order
    localparam logic [2:0] NBR_YP   = 3'd0;
    localparam logic [2:0] NBR_YM   = 3'd1;
    localparam logic [2:0] NBR_XP   = 3'd2;
    localparam logic [2:0] NBR_XM   = 3'd3;
    localparam logic [2:0] NBR_ZP   = 3'd4;
    localparam logic [2:0] NBR_ZM   = 3'd5;
    localparam logic [2:0] NBR_LAST = 3'd6;

endpackage

`default_nettype wire

/* hdl/voxel_occupancy_grid.sv */
`default_nettype none

// Set, clear and query pass through S_MULA, S_MULB, S_READ, S_EVAL and S_DONE before o_m_axis_tvalid;
// an isolation probe of an occupied voxel adds S_NBR, and out-of-range coordinates go from S_MULA to S_DONE.
// One item at a time: the next word is taken in the cycle after the result is loaded;
// the probe's seven reads go one per cycle through the single occupancy memory port.
// After reset the occupancy memory is swept empty, one cell a cycle;
// the input is not ready during the sweep, the edge register is.
module voxel_occupancy_grid #(
    parameter int MAX_EDGE     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // Edge length register write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [vog_pkg::EDGE_W-1:0]        i_cfg_data,

    // Input items
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: x_coord[3:0], y_coord[7:4], z_coord[11:8], payload_in[43:12], zero pad
    input  wire logic [vog_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: func[1:0]
    input  wire logic [vog_pkg::FUNC_W-1:0]        i_s_axis_tuser,

    // Result items
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: status[1:0], present[2], isolated[3], payload_out[35:4], zero pad
    output logic [vog_pkg::M_TDATA_W-1:0]          o_m_axis_tdata
);

    localparam int CELLS = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int IW    = $clog2(CELLS);
    localparam int CW    = vog_pkg::COORD_W;
    localparam int EW    = vog_pkg::EDGE_W;
    localparam int AW    = vog_pkg::ACC_W;
    localparam int PB    = PAYLOAD_BITS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MULA  = 8'b0000_0100,
        S_MULB  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_EVAL  = 8'b0010_0000,
        S_NBR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // Control and work registers
    t_state                     r_state, n_state;
    logic [EW-1:0]              r_edge, n_edge;
    logic [IW-1:0]              r_esq, n_esq;
    logic [IW-1:0]              r_clr, n_clr;
    vog_pkg::t_func             r_func, n_func;
    logic [CW-1:0]              r_x, n_x;
    logic [CW-1:0]              r_y, n_y;
    logic [CW-1:0]              r_z, n_z;
    logic [PB-1:0]              r_pay, n_pay;
    logic [AW-1:0]              r_acc, n_acc;
    logic [IW-1:0]              r_idx, n_idx;
    logic [2:0]                 r_k, n_k;
    logic                       r_pend, n_pend;
    logic                       r_any, n_any;
    vog_pkg::t_status           r_status, n_status;
    logic                       r_present, n_present;
    logic                       r_isolated, n_isolated;
    logic [PB-1:0]              r_rpay, n_rpay;
    logic                       r_m_valid, n_m_valid;
    logic [vog_pkg::M_TDATA_W-1:0] r_m_data, n_m_data;

    // Memories and their registered read data
    logic                       r_occ_mem [CELLS];
    logic [PB-1:0]              r_attr_mem [CELLS];
    logic                       r_occ_q;
    logic [PB-1:0]              r_attr_q;

    // Memory controls
    logic                       occ_we;
    logic                       occ_wdata;
    logic [IW-1:0]              occ_waddr;
    logic [IW-1:0]              occ_raddr;
    logic                       attr_we;
    logic [IW-1:0]              attr_addr;

    // Shared multiply-add unit
    logic [AW-1:0]              mul_a;
    logic [AW-1:0]              mul_b;
    logic [AW-1:0]              mul_out;

    // Neighbor address unit
    logic [IW-1:0]              nbr_off;
    logic                       nbr_sub;
    logic                       nbr_ok;
    logic [IW-1:0]              nbr_addr;

    logic [EW-1:0]              eff;
    logic                       in_cube;
    logic                       s_acc;
    logic [63:0]                in_pay64;
    logic [63:0]                out_pay64;

    // Clamp edge to the cube size
    always_comb begin
        if (32'(r_edge) > MAX_EDGE) begin
            eff = EW'(MAX_EDGE);
        end else begin
            eff = r_edge;
        end
    end

    assign in_cube = (EW'(r_x) < eff) && (EW'(r_y) < eff) && (EW'(r_z) < eff);

    // Multiply-add: a * edge + b
    assign mul_out = mul_a * AW'(eff) + mul_b;

    always_comb begin
        case (r_state)
            S_MULA: begin
                mul_a = AW'(r_z);
                mul_b = AW'(r_y);
            end
            S_MULB: begin
                mul_a = r_acc;
                mul_b = AW'(r_x);
            end
            default: begin
                mul_a = AW'(eff);
                mul_b = '0;
            end
        endcase
    end

    // Pick the neighbor offset and whether it lies inside the cube
    always_comb begin
        case (r_k)
            vog_pkg::NBR_YP: begin
                nbr_off = IW'(eff);
                nbr_sub = 1'b0;
                nbr_ok  = (EW'(r_y) + EW'(1)) < eff;
            end
            vog_pkg::NBR_YM: begin
                nbr_off = IW'(eff);
                nbr_sub = 1'b1;
                nbr_ok  = r_y != '0;
            end
            vog_pkg::NBR_XP: begin
                nbr_off = IW'(1);
                nbr_sub = 1'b0;
                nbr_ok  = (EW'(r_x) + EW'(1)) < eff;
            end
            vog_pkg::NBR_XM: begin
                nbr_off = IW'(1);
                nbr_sub = 1'b1;
                nbr_ok  = r_x != '0;
            end
            vog_pkg::NBR_ZP: begin
                nbr_off = r_esq;
                nbr_sub = 1'b0;
                nbr_ok  = (EW'(r_z) + EW'(1)) < eff;
            end
            vog_pkg::NBR_ZM: begin
                nbr_off = r_esq;
                nbr_sub = 1'b1;
                nbr_ok  = r_z != '0;
            end
            default: begin
                nbr_off = '0;
                nbr_sub = 1'b0;
                nbr_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (!nbr_ok) begin
            nbr_addr = r_idx;
        end else if (nbr_sub) begin
            nbr_addr = r_idx - nbr_off;
        end else begin
            nbr_addr = r_idx + nbr_off;
        end
    end

    // Payload width adaption on both sides
    assign in_pay64 = {32'b0, i_s_axis_tdata[43:12]};

    always_comb begin
        out_pay64 = '0;
        out_pay64[PB-1:0] = r_rpay;
    end

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_edge     = r_edge;
        n_esq      = r_esq;
        n_clr      = r_clr;
        n_func     = r_func;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_pay      = r_pay;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_k        = r_k;
        n_pend     = r_pend;
        n_any      = r_any;
        n_status   = r_status;
        n_present  = r_present;
        n_isolated = r_isolated;
        n_rpay     = r_rpay;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;

        occ_we     = 1'b0;
        occ_wdata  = 1'b0;
        occ_waddr  = r_idx;
        occ_raddr  = r_idx;
        attr_we    = 1'b0;
        attr_addr  = r_idx;

        // Take the edge register word
        if (i_cfg_valid) begin
            n_edge = i_cfg_data;
        end

        // Drop the result once the sink takes it
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                occ_we    = 1'b1;
                occ_wdata = 1'b0;
                occ_waddr = r_clr;
                n_clr     = r_clr + IW'(1);
                if (r_clr == IW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_esq = IW'(mul_out);
                if (s_acc) begin
                    n_func  = vog_pkg::t_func'(i_s_axis_tuser);
                    n_x     = i_s_axis_tdata[3:0];
                    n_y     = i_s_axis_tdata[7:4];
                    n_z     = i_s_axis_tdata[11:8];
                    n_pay   = in_pay64[PB-1:0];
                    n_state = S_MULA;
                end
            end
            S_MULA: begin
                n_acc      = mul_out;
                n_isolated = 1'b0;
                if (!in_cube) begin
                    n_status  = vog_pkg::STAT_RANGE;
                    n_present = 1'b0;
                    n_rpay    = '0;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_MULB;
                end
            end
            S_MULB: begin
                n_acc   = mul_out;
                n_state = S_READ;
            end
            S_READ: begin
                occ_raddr = IW'(r_acc);
                attr_addr = IW'(r_acc);
                n_idx     = IW'(r_acc);
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                case (r_func)
                    vog_pkg::FUNC_SET: begin
                        occ_we    = 1'b1;
                        occ_wdata = 1'b1;
                        attr_we   = 1'b1;
                        n_status  = vog_pkg::STAT_OK;
                        n_present = 1'b1;
                        n_rpay    = r_pay;
                    end
                    vog_pkg::FUNC_CLEAR: begin
                        n_present = 1'b0;
                        n_rpay    = '0;
                        if (r_occ_q) begin
                            occ_we    = 1'b1;
                            occ_wdata = 1'b0;
                            n_status  = vog_pkg::STAT_OK;
                        end else begin
                            n_status = vog_pkg::STAT_ABSENT;
                        end
                    end
                    default: begin
                        if (r_occ_q) begin
                            n_status  = vog_pkg::STAT_OK;
                            n_present = 1'b1;
                            n_rpay    = r_attr_q;
                            if (r_func == vog_pkg::FUNC_PROBE) begin
                                n_k     = '0;
                                n_pend  = 1'b0;
                                n_any   = 1'b0;
                                n_state = S_NBR;
                            end
                        end else begin
                            n_status  = vog_pkg::STAT_ABSENT;
                            n_present = 1'b0;
                            n_rpay    = '0;
                        end
                    end
                endcase
            end
            S_NBR: begin
                // Issue one neighbor read a cycle, fold in the previous one
                occ_raddr = nbr_addr;
                n_pend    = nbr_ok;
                if (r_pend && r_occ_q) begin
                    n_any = 1'b1;
                end
                n_k = r_k + 3'd1;
                if (r_k == vog_pkg::NBR_LAST) begin
                    n_isolated = !(r_any || (r_pend && r_occ_q));
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // Load the output word when the slot is free
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {4'b0, out_pay64[vog_pkg::OUT_PAY_W-1:0],
                                 r_isolated, r_present, r_status};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_edge    <= vog_pkg::EDGE_RESET;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_edge    <= n_edge;
            r_clr     <= n_clr;
            r_m_valid <= n_m_valid;
            r_k       <= n_k;
            r_pend    <= n_pend;
            r_any     <= n_any;
        end
    end

    // Work and payload registers
    always_ff @(posedge i_clk) begin
        r_esq      <= n_esq;
        r_func     <= n_func;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_pay      <= n_pay;
        r_acc      <= n_acc;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_present  <= n_present;
        r_isolated <= n_isolated;
        r_rpay     <= n_rpay;
        r_m_data   <= n_m_data;
    end

    // Occupancy memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ_mem[occ_waddr] <= occ_wdata;
        end
        r_occ_q <= r_occ_mem[occ_raddr];
    end

    // Attribute memory: single port, registered read
    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            r_attr_mem[attr_addr] <= r_pay;
        end
        r_attr_q <= r_attr_mem[attr_addr];
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

/* tb/voxel_occupancy_grid_tb.sv */
module voxel_occupancy_grid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_EDGE     = 16;
    localparam int CELL_COUNT   = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_LIMIT  = 40;

    // One operation word and one response word, in field terms
    typedef struct packed {
        vog_pkg::t_func func;
        logic [3:0]     x;
        logic [3:0]     y;
        logic [3:0]     z;
        logic [31:0]    payload;
    } t_voxel_op;

    typedef struct packed {
        vog_pkg::t_status status;
        logic             present;
        logic             isolated;
        logic [31:0]      payload;
    } t_voxel_resp;

    // Directed row: either an edge write or an operation, optionally with a fixed response
    typedef struct {
        bit          edge_write;
        logic [4:0]  edge_val;
        t_voxel_op   op;
        bit          fixed;
        t_voxel_resp resp;
    } t_stim_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [4:0]  cfg_data   = '0;
    logic        s_tvalid   = 1'b0;
    logic [47:0] s_tdata    = '0;
    logic [1:0]  s_tuser    = '0;
    logic        m_tready   = 1'b0;

    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;

    // Shadow copy of the grid and the edge register
    bit          grid_occ  [CELL_COUNT];
    logic [31:0] grid_attr [CELL_COUNT];
    logic [4:0]  edge_setting = vog_pkg::EDGE_RESET;

    t_voxel_resp pending_resps [$];
    t_stim_row   directed_rows [$];
    int unsigned n_results    = 0;
    int unsigned n_mismatches = 0;
    bit          sender_burst = 1'b0;

    voxel_occupancy_grid #(
        .MAX_EDGE     (MAX_EDGE),
        .PAYLOAD_BITS (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("FAIL voxel_occupancy_grid");
        $finish;
    end

    function automatic int unsigned eff_edge();
        return (edge_setting > MAX_EDGE) ? MAX_EDGE : edge_setting;
    endfunction

    // Neighbors outside the cube count as empty
    function automatic bit cell_filled(int x, int y, int z);
        int e = eff_edge();
        if (x < 0 || y < 0 || z < 0 || x >= e || y >= e || z >= e)
            return 1'b0;
        return grid_occ[z * e * e + y * e + x];
    endfunction

    // Work out the response to one operation and update the shadow grid
    function automatic t_voxel_resp apply_voxel_op(t_voxel_op op);
        t_voxel_resp r;
        int e = eff_edge();
        int x = op.x;
        int y = op.y;
        int z = op.z;
        int idx;
        r = '0;
        if (x >= e || y >= e || z >= e) begin
            r.status = vog_pkg::STAT_RANGE;
            return r;
        end
        idx = z * e * e + y * e + x;
        case (op.func)
            vog_pkg::FUNC_SET: begin
                grid_occ[idx]  = 1'b1;
                grid_attr[idx] = op.payload;
                r.present      = 1'b1;
                r.payload      = op.payload;
            end
            vog_pkg::FUNC_CLEAR: begin
                if (!grid_occ[idx])
                    r.status = vog_pkg::STAT_ABSENT;
                else
                    grid_occ[idx] = 1'b0;
            end
            default: begin
                if (!grid_occ[idx]) begin
                    r.status = vog_pkg::STAT_ABSENT;
                end else begin
                    r.present = 1'b1;
                    r.payload = grid_attr[idx];
                    if (op.func == vog_pkg::FUNC_PROBE)
                        r.isolated = !(cell_filled(x, y + 1, z) || cell_filled(x, y - 1, z) ||
                                       cell_filled(x + 1, y, z) || cell_filled(x - 1, y, z) ||
                                       cell_filled(x, y, z + 1) || cell_filled(x, y, z - 1));
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_voxel_op make_op(vog_pkg::t_func f, int x, int y, int z,
                                          logic [31:0] pay);
        t_voxel_op op;
        op.func    = f;
        op.x       = 4'(x);
        op.y       = 4'(y);
        op.z       = 4'(z);
        op.payload = pay;
        return op;
    endfunction

    function automatic void add_item(vog_pkg::t_func f, int x, int y, int z, logic [31:0] pay);
        t_stim_row row;
        row.edge_write = 1'b0;
        row.edge_val   = '0;
        row.op         = make_op(f, x, y, z, pay);
        row.fixed      = 1'b0;
        row.resp       = '0;
        directed_rows.push_back(row);
    endfunction

    // Row whose response is known without the predictor; isolated is always 0 here
    function automatic void add_checked(vog_pkg::t_func f, int x, int y, int z,
                                        logic [31:0] pay, vog_pkg::t_status st,
                                        logic pres, logic [31:0] pout);
        t_stim_row row;
        row.edge_write    = 1'b0;
        row.edge_val      = '0;
        row.op            = make_op(f, x, y, z, pay);
        row.fixed         = 1'b1;
        row.resp.status   = st;
        row.resp.present  = pres;
        row.resp.isolated = 1'b0;
        row.resp.payload  = pout;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_edge_write(logic [4:0] v);
        t_stim_row row;
        row.edge_write = 1'b1;
        row.edge_val   = v;
        row.op         = '0;
        row.fixed      = 1'b0;
        row.resp       = '0;
        directed_rows.push_back(row);
    endfunction

    // Mostly in-range coordinates, bunched at the corners so cells collide
    function automatic logic [3:0] random_coord();
        int unsigned e = eff_edge();
        int unsigned r = $urandom_range(0, 99);
        int unsigned span;
        span = (e < 4) ? e : 4;
        if (e == 0 || r < 8)
            return 4'($urandom_range(0, 15));
        if (r < 50)
            return 4'($urandom_range(0, e - 1));
        if (r < 75)
            return 4'($urandom_range(0, span - 1));
        return 4'($urandom_range(e - span, e - 1));
    endfunction

    function automatic t_voxel_op random_voxel_op();
        t_voxel_op op;
        int unsigned r = $urandom_range(0, 99);
        op.func    = (r < 35) ? vog_pkg::FUNC_SET : (r < 50) ? vog_pkg::FUNC_CLEAR :
                     (r < 70) ? vog_pkg::FUNC_QUERY : vog_pkg::FUNC_PROBE;
        op.x       = random_coord();
        op.y       = random_coord();
        op.z       = random_coord();
        op.payload = $urandom();
        return op;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (n_mismatches < PRINT_LIMIT)
            $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                     $time, n_results, what, got, want);
        n_mismatches++;
    endtask

    // Offer one operation word, then record its expected response on accept
    task automatic send_voxel_op(t_voxel_op op, bit fixed, t_voxel_resp fixed_resp);
        int unsigned gap;
        t_voxel_resp r;
        gap = sender_burst ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, op.payload, op.z, op.y, op.x};
        s_tuser  <= op.func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = apply_voxel_op(op);
        pending_resps.push_back(fixed ? fixed_resp : r);
    endtask

    // Drain outstanding responses, then write the edge register
    task automatic write_edge(logic [4:0] v);
        s_tvalid <= 1'b0;
        while (pending_resps.size() != 0) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        edge_setting = v;
    endtask

    // Response side: random stalls, one long hold-off, and stall-free stretches
    initial begin : response_check
        t_voxel_resp want;
        logic [1:0]  got_status;
        logic        got_present;
        logic        got_isolated;
        logic [31:0] got_payload;
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_results == 120)
                gap = LONG_HOLD;
            else if ((n_results / 40) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 18);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got_status   = o_m_axis_tdata[1:0];
            got_present  = o_m_axis_tdata[2];
            got_isolated = o_m_axis_tdata[3];
            got_payload  = o_m_axis_tdata[35:4];
            n_results++;
            if (pending_resps.size() == 0) begin
                report_mismatch("unexpected word", o_m_axis_tdata, 0);
            end else begin
                want = pending_resps.pop_front();
                if (got_status !== want.status)
                    report_mismatch("status", got_status, want.status);
                if (got_present !== want.present)
                    report_mismatch("present", got_present, want.present);
                if (got_isolated !== want.isolated)
                    report_mismatch("isolated", got_isolated, want.isolated);
                if (got_payload !== want.payload)
                    report_mismatch("payload", got_payload, want.payload);
            end
        end
    end

    // Stimulus: directed rows, then random phases under a range of edge settings
    initial begin : stimulus
        logic [4:0]  phase_edges [12];
        int unsigned n_items;
        t_voxel_op   op;

        phase_edges = '{5'd16, 5'd3, 5'd31, 5'd2, 5'd1, 5'd0,
                        5'd5, 5'd16, 5'd4, 5'd8, 5'd2, 5'd16};

        // Empty grid after reset
        add_checked(vog_pkg::FUNC_QUERY, 0, 0, 0, 32'h0,
                    vog_pkg::STAT_ABSENT, 1'b0, 32'h0);
        add_checked(vog_pkg::FUNC_CLEAR, 15, 15, 15, 32'h0,
                    vog_pkg::STAT_ABSENT, 1'b0, 32'h0);
        add_checked(vog_pkg::FUNC_PROBE, 7, 7, 7, 32'hFFFF_FFFF,
                    vog_pkg::STAT_ABSENT, 1'b0, 32'h0);
        // Corner cells with extreme payloads
        add_checked(vog_pkg::FUNC_SET, 0, 0, 0, 32'h0,
                    vog_pkg::STAT_OK, 1'b1, 32'h0);
        add_checked(vog_pkg::FUNC_SET, 15, 15, 15, 32'hFFFF_FFFF,
                    vog_pkg::STAT_OK, 1'b1, 32'hFFFF_FFFF);
        add_item(vog_pkg::FUNC_PROBE, 15, 15, 15, 32'h0);
        add_item(vog_pkg::FUNC_PROBE, 0, 0, 0, 32'h0);
        add_item(vog_pkg::FUNC_SET, 1, 0, 0, 32'hA5A5_5A5A);
        add_item(vog_pkg::FUNC_PROBE, 0, 0, 0, 32'h0);
        // Center cell with neighbors along y, then z
        add_item(vog_pkg::FUNC_SET, 8, 8, 8, 32'h1234_5678);
        add_item(vog_pkg::FUNC_SET, 8, 9, 8, 32'h8765_4321);
        add_item(vog_pkg::FUNC_PROBE, 8, 8, 8, 32'h0);
        add_checked(vog_pkg::FUNC_CLEAR, 8, 9, 8, 32'h0,
                    vog_pkg::STAT_OK, 1'b0, 32'h0);
        add_item(vog_pkg::FUNC_SET, 8, 8, 7, 32'h0F0F_F0F0);
        add_item(vog_pkg::FUNC_PROBE, 8, 8, 8, 32'h0);
        add_item(vog_pkg::FUNC_CLEAR, 8, 8, 7, 32'h0);
        add_item(vog_pkg::FUNC_PROBE, 8, 8, 8, 32'h0);
        add_checked(vog_pkg::FUNC_CLEAR, 8, 8, 8, 32'h0,
                    vog_pkg::STAT_OK, 1'b0, 32'h0);
        add_checked(vog_pkg::FUNC_CLEAR, 8, 8, 8, 32'h0,
                    vog_pkg::STAT_ABSENT, 1'b0, 32'h0);
        // Coordinates at and beyond a small edge
        add_edge_write(5'd5);
        add_checked(vog_pkg::FUNC_SET, 5, 0, 0, 32'hDEAD_BEEF,
                    vog_pkg::STAT_RANGE, 1'b0, 32'h0);
        add_checked(vog_pkg::FUNC_PROBE, 0, 0, 5, 32'h0,
                    vog_pkg::STAT_RANGE, 1'b0, 32'h0);
        // Zero edge rejects everything
        add_edge_write(5'd0);
        add_checked(vog_pkg::FUNC_QUERY, 0, 0, 0, 32'h0,
                    vog_pkg::STAT_RANGE, 1'b0, 32'h0);
        // Edge above the maximum saturates
        add_edge_write(5'd31);
        add_item(vog_pkg::FUNC_QUERY, 15, 15, 15, 32'h0);
        // Single-cell cube: every neighbor lies outside
        add_edge_write(5'd1);
        add_item(vog_pkg::FUNC_PROBE, 0, 0, 0, 32'h0);
        add_checked(vog_pkg::FUNC_SET, 0, 1, 0, 32'h5555_AAAA,
                    vog_pkg::STAT_RANGE, 1'b0, 32'h0);

        // Hold reset while the clock runs, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].edge_write)
                write_edge(directed_rows[i].edge_val);
            else
                send_voxel_op(directed_rows[i].op, directed_rows[i].fixed,
                              directed_rows[i].resp);
        end

        foreach (phase_edges[p]) begin
            write_edge(phase_edges[p]);
            sender_burst = (p % 4 == 1);
            n_items = (phase_edges[p] == 0) ? 10 : (phase_edges[p] == 1) ? 20 : 40;
            repeat (n_items) begin
                op = random_voxel_op();
                send_voxel_op(op, 1'b0, '0);
            end
        end

        // Drain and let the pipeline settle
        s_tvalid <= 1'b0;
        while (pending_resps.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_mismatches == 0)
            $display("PASS voxel_occupancy_grid");
        else
            $display("FAIL voxel_occupancy_grid");
        $finish;
    end

endmodule

/* voxel_occupancy_grid.f */
hdl/vog_pkg.sv
hdl/voxel_occupancy_grid.sv
tb/voxel_occupancy_grid_tb.sv
